[hdl/at3d_pkg.sv]
// at3d_pkg: shared types, codes and helpers of the 3D affine transform block.
// No dependencies; used by every module under hdl/.
package at3d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 8;
  localparam int NUM_PAIRS     = 8;
  localparam int DIV_STEP      = 4;   // quotient bits per divider stage

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_VECTOR = 2'd1;
  localparam logic [1:0] KIND_RAY    = 2'd2;
  localparam logic [1:0] KIND_BOX    = 2'd3;

  localparam logic [2:0] RAY_LAST_SLOT = 3'd1;
  localparam logic [2:0] BOX_LAST_SLOT = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  // How a slot's mapped coordinates fold into the result
  typedef enum logic [1:0] {
    ROLE_FIRST,
    ROLE_SECOND,
    ROLE_BOX
  } role_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    role_t role;
    logic  is_vec;
  } tag_t;

  typedef logic [NUM_PAIRS-1:0][CFG_W-1:0] mat_regs_t;

  // Matrix entry e = 4*row + col; odd entries sit in the upper half of a pair
  function automatic coord_t mat_entry(input mat_regs_t m, input logic [3:0] e);
    logic [CFG_W-1:0] pair;
    pair = m[e[3:1]];
    return e[0] ? coord_t'(pair[63:32]) : coord_t'(pair[31:0]);
  endfunction

endpackage

[hdl/at3d_div.sv]
// at3d_div: pipelined unsigned restoring divider, DIV_STEP quotient bits a stage.
// Depends on at3d_pkg.
module at3d_div #(
  parameter int FRAC_BITS = at3d_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic [32+FRAC_BITS-1:0]   dividend,
  input  logic [31:0]               divisor,
  output logic [32+FRAC_BITS-1:0]   quotient
);
  import at3d_pkg::*;

  localparam int DivW      = 32 + FRAC_BITS;
  localparam int DivStages = (DivW + DIV_STEP - 1) / DIV_STEP;
  localparam int PadW      = DivStages * DIV_STEP;

  logic [32:0]     rem_q [DivStages];
  logic [PadW-1:0] num_q [DivStages];
  logic [PadW-1:0] quo_q [DivStages];
  logic [31:0]     den_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [32:0]     r_in, r_nx;
    logic [PadW-1:0] n_in, n_nx, q_in, q_nx;
    logic [31:0]     d_in;

    if (s == 0) begin : g_head
      assign r_in = '0;
      assign n_in = PadW'(dividend);
      assign q_in = '0;
      assign d_in = divisor;
    end else begin : g_body
      assign r_in = rem_q[s-1];
      assign n_in = num_q[s-1];
      assign q_in = quo_q[s-1];
      assign d_in = den_q[s-1];
    end

    always_comb begin
      r_nx = r_in;
      n_nx = n_in;
      q_nx = q_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        r_nx = {r_nx[31:0], n_nx[PadW-1]};
        n_nx = n_nx << 1;
        if (r_nx >= {1'b0, d_in}) begin
          r_nx = r_nx - {1'b0, d_in};
          q_nx = {q_nx[PadW-2:0], 1'b1};
        end else begin
          q_nx = {q_nx[PadW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= r_nx;
      num_q[s] <= n_nx;
      quo_q[s] <= q_nx;
      den_q[s] <= d_in;
    end
  end

  assign quotient = quo_q[DivStages-1][DivW-1:0];

endmodule

[hdl/at3d_xform.sv]
// at3d_xform: shared point/vector transform pipeline (products, row sums,
// floor shift and saturation, divide by w). Depends on at3d_pkg and at3d_div.
module at3d_xform #(
  parameter int FRAC_BITS = at3d_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  at3d_pkg::mat_regs_t   mat,
  input  at3d_pkg::tag_t        in_tag,
  input  at3d_pkg::vec3_t       in_pt,
  output at3d_pkg::tag_t        out_tag,
  output at3d_pkg::vec3_t       out_pt,
  output logic                  out_wz
);
  import at3d_pkg::*;

  localparam int DivW      = 32 + FRAC_BITS;
  localparam int DivStages = (DivW + DIV_STEP - 1) / DIV_STEP;
  localparam int SumW      = 66;
  localparam coord_t ONE   = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t CMAX  = coord_t'(32'h7fff_ffff);
  localparam coord_t CMIN  = coord_t'(32'h8000_0000);

  function automatic coord_t sat_row(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] sh;
    sh = s >>> FRAC_BITS;
    if ((&sh[SumW-1:31]) || (~|sh[SumW-1:31])) return coord_t'(sh[31:0]);
    else if (sh[SumW-1]) return CMIN;
    else return CMAX;
  endfunction

  // stage 1: products
  tag_t               tag1;
  logic signed [63:0] prod [4][3];
  coord_t             trans [4];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      prod[r][0] <= mat_entry(mat, 4'(4*r))     * in_pt.x;
      prod[r][1] <= mat_entry(mat, 4'(4*r + 1)) * in_pt.y;
      prod[r][2] <= mat_entry(mat, 4'(4*r + 2)) * in_pt.z;
      trans[r]   <= mat_entry(mat, 4'(4*r + 3));
    end
  end

  // stage 2: exact row sums
  tag_t                   tag2;
  logic signed [SumW-1:0] rsum [4];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      rsum[r] <= SumW'(prod[r][0]) + SumW'(prod[r][1]) + SumW'(prod[r][2]) +
                 (tag1.is_vec ? '0 : (SumW'(trans[r]) <<< FRAC_BITS));
    end
  end

  // stage 3: floor shift and saturate
  tag_t   tag3;
  coord_t crd3 [3];
  coord_t w3;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) crd3[r] <= sat_row(rsum[r]);
    w3 <= sat_row(rsum[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= in_tag;
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  // divide lanes: |c| * ONE / |w|
  logic [31:0]     w_abs;
  logic [DivW-1:0] quo [3];

  assign w_abs = w3[31] ? 32'(-w3) : 32'(w3);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [31:0] c_abs;
    assign c_abs = crd3[l][31] ? 32'(-crd3[l]) : 32'(crd3[l]);
    at3d_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .dividend ({c_abs, {FRAC_BITS{1'b0}}}),
      .divisor  (w_abs),
      .quotient (quo[l])
    );
  end

  // side data held alongside the divider
  tag_t   dl_tag  [DivStages];
  coord_t dl_crd  [DivStages][3];
  logic   dl_neg  [DivStages][3];
  logic   dl_wone [DivStages];
  logic   dl_wzero[DivStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DivStages; i++) dl_tag[i] <= '0;
    end else begin
      dl_tag[0] <= tag3;
      for (int i = 1; i < DivStages; i++) dl_tag[i] <= dl_tag[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      dl_crd[0][l] <= crd3[l];
      dl_neg[0][l] <= crd3[l][31] ^ w3[31];
    end
    dl_wone[0]  <= (w3 == ONE);
    dl_wzero[0] <= (w3 == '0);
    for (int i = 1; i < DivStages; i++) begin
      dl_crd[i]   <= dl_crd[i-1];
      dl_neg[i]   <= dl_neg[i-1];
      dl_wone[i]  <= dl_wone[i-1];
      dl_wzero[i] <= dl_wzero[i-1];
    end
  end

  // final select with quotient saturation
  coord_t res [3];
  tag_t   tl;

  assign tl = dl_tag[DivStages-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic hi_zero;
      logic fits;
      hi_zero = ~|quo[l][DivW-1:32];
      if (dl_neg[DivStages-1][l])
        fits = hi_zero && (!quo[l][31] || (~|quo[l][30:0]));
      else
        fits = hi_zero && !quo[l][31];
      if (tl.is_vec || dl_wone[DivStages-1])
        res[l] = dl_crd[DivStages-1][l];
      else if (dl_wzero[DivStages-1])
        res[l] = '0;
      else if (!fits)
        res[l] = dl_neg[DivStages-1][l] ? CMIN : CMAX;
      else if (dl_neg[DivStages-1][l])
        res[l] = coord_t'(-quo[l][31:0]);
      else
        res[l] = coord_t'(quo[l][31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else begin
      out_tag <= tl;
    end
  end

  always_ff @(posedge clk) begin
    out_pt.x <= res[0];
    out_pt.y <= res[1];
    out_pt.z <= res[2];
    out_wz   <= !tl.is_vec && dl_wzero[DivStages-1];
  end

endmodule

[hdl/at3d_flags.sv]
// at3d_flags: matrix property pipeline, column scale test and 3x3 determinant sign.
// Depends on at3d_pkg.
module at3d_flags #(
  parameter int FRAC_BITS = at3d_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  at3d_pkg::mat_regs_t mat,
  output logic                has_scale,
  output logic                flips_handedness
);
  import at3d_pkg::*;

  localparam logic [63:0] ONE2   = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] LO_THR = (ONE2 * 64'd999 + 64'd999) / 64'd1000;
  localparam logic [63:0] HI_THR = (ONE2 * 64'd1001) / 64'd1000;

  // scale: squares, then column lengths against the window
  logic [63:0] sq [3][3];
  logic        scale_q;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        sq[c][r] <= 64'(mat_entry(mat, 4'(4*r + c))) * 64'(mat_entry(mat, 4'(4*r + c)));
      end
    end
  end

  always_comb begin
    scale_q = 1'b0;
    for (int c = 0; c < 3; c++) begin
      logic [63:0] len;
      len = sq[c][0] + sq[c][1] + sq[c][2];
      if (len < LO_THR || len > HI_THR) scale_q = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    has_scale <= scale_q;
  end

  // determinant: cofactor products, cofactors, split partials, sum
  logic signed [63:0] cp [6];
  logic signed [63:0] cof [3];
  logic signed [65:0] part_lo [3];
  logic signed [62:0] part_hi [3];
  logic signed [99:0] det;

  always_ff @(posedge clk) begin
    cp[0] <= mat_entry(mat, 4'd5) * mat_entry(mat, 4'd10);
    cp[1] <= mat_entry(mat, 4'd6) * mat_entry(mat, 4'd9);
    cp[2] <= mat_entry(mat, 4'd4) * mat_entry(mat, 4'd10);
    cp[3] <= mat_entry(mat, 4'd6) * mat_entry(mat, 4'd8);
    cp[4] <= mat_entry(mat, 4'd4) * mat_entry(mat, 4'd9);
    cp[5] <= mat_entry(mat, 4'd5) * mat_entry(mat, 4'd8);
  end

  // cofactors wrap at 64 bits; second cofactor is stored negated
  always_ff @(posedge clk) begin
    cof[0] <= cp[0] - cp[1];
    cof[1] <= cp[3] - cp[2];
    cof[2] <= cp[4] - cp[5];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      part_lo[k] <= $signed({1'b0, cof[k][32:0]}) * mat_entry(mat, 4'(k));
      part_hi[k] <= $signed(cof[k][63:33]) * mat_entry(mat, 4'(k));
    end
  end

  always_comb begin
    det = '0;
    for (int k = 0; k < 3; k++) begin
      det = det + $signed({{4{part_hi[k][62]}}, part_hi[k], 33'b0})
                + $signed({{34{part_lo[k][65]}}, part_lo[k]});
    end
  end

  always_ff @(posedge clk) begin
    flips_handedness <= det[99];
  end

endmodule

[hdl/affine_transform_3d.sv]
// affine_transform_3d: top level; matrix registers, slot issue, result folding.
// Depends on at3d_pkg, at3d_xform, at3d_div, at3d_flags.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  config    | cfg_we                | cfg_index, cfg_data
//  item in   | start & !busy         | kind, first_x/y/z, second_x/y/z
//  result    | done (one-cycle)      | out_first_*, out_second_*, w_zero,
//            |                       | has_scale, flips_handedness
//
// Each item issues slots into one shared transform pipeline: point and vector
// take one slot, a ray two, a box eight (one per corner), so issue rate is
// one slot per cycle and busy is high while a ray or box issues its rest.
// A transfer passes the issue register, the product, row sum, saturate and
// divider stages and the transform output register, then result regs and done.
// Sync rst restores the identity matrix; results are in order, never held off.
module affine_transform_3d #(
  parameter int FRAC_BITS = at3d_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [at3d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [at3d_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         kind,
  input  logic signed [31:0]                 first_x,
  input  logic signed [31:0]                 first_y,
  input  logic signed [31:0]                 first_z,
  input  logic signed [31:0]                 second_x,
  input  logic signed [31:0]                 second_y,
  input  logic signed [31:0]                 second_z,
  output logic                               done,
  output logic signed [31:0]                 out_first_x,
  output logic signed [31:0]                 out_first_y,
  output logic signed [31:0]                 out_first_z,
  output logic signed [31:0]                 out_second_x,
  output logic signed [31:0]                 out_second_y,
  output logic signed [31:0]                 out_second_z,
  output logic                               w_zero,
  output logic                               has_scale,
  output logic                               flips_handedness
);
  import at3d_pkg::*;

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (32 + FRAC_BITS);
  localparam mat_regs_t MAT_RESET = {ONE_HI, CFG_W'(0), ONE_LO, CFG_W'(0),
                                     CFG_W'(0), ONE_HI, CFG_W'(0), ONE_LO};

  // matrix registers
  mat_regs_t mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (cfg_we && (~|cfg_index[CFG_IDX_W-1:3])) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  // slot issue
  logic       accept;
  logic [2:0] slot, slot_next, cur_slot;
  logic [1:0] kind_q, cur_kind;
  vec3_t      a_q, b_q, cur_a, cur_b, iss_pt_next, iss_pt;
  tag_t       iss_tag_next, iss_tag;
  logic       busy_next;

  assign accept   = start && !busy;
  assign cur_slot = accept ? 3'd0 : slot;
  assign cur_kind = accept ? kind : kind_q;
  assign cur_a    = accept ? vec3_t'{first_x, first_y, first_z} : a_q;
  assign cur_b    = accept ? vec3_t'{second_x, second_y, second_z} : b_q;

  always_comb begin
    iss_tag_next.valid  = accept || busy;
    iss_tag_next.first  = (cur_slot == 3'd0);
    iss_tag_next.last   = 1'b1;
    iss_tag_next.role   = ROLE_FIRST;
    iss_tag_next.is_vec = 1'b0;
    iss_pt_next         = cur_a;
    unique case (cur_kind)
      KIND_POINT: begin
      end
      KIND_VECTOR: begin
        iss_tag_next.is_vec = 1'b1;
      end
      KIND_RAY: begin
        if (cur_slot == RAY_LAST_SLOT) begin
          iss_tag_next.role   = ROLE_SECOND;
          iss_tag_next.is_vec = 1'b1;
          iss_pt_next         = cur_b;
        end else begin
          iss_tag_next.last = 1'b0;
        end
      end
      default: begin
        iss_tag_next.role = ROLE_BOX;
        iss_tag_next.last = (cur_slot == BOX_LAST_SLOT);
        iss_pt_next.x     = cur_slot[0] ? cur_b.x : cur_a.x;
        iss_pt_next.y     = cur_slot[1] ? cur_b.y : cur_a.y;
        iss_pt_next.z     = cur_slot[2] ? cur_b.z : cur_a.z;
      end
    endcase
  end

  always_comb begin
    busy_next = busy;
    slot_next = slot;
    if (accept) begin
      busy_next = !iss_tag_next.last;
      slot_next = 3'd1;
    end else if (busy) begin
      busy_next = !iss_tag_next.last;
      slot_next = slot + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      slot    <= '0;
      iss_tag <= '0;
    end else begin
      busy    <= busy_next;
      slot    <= slot_next;
      iss_tag <= iss_tag_next;
    end
  end

  always_ff @(posedge clk) begin
    iss_pt <= iss_pt_next;
    if (accept) begin
      kind_q <= kind;
      a_q    <= cur_a;
      b_q    <= cur_b;
    end
  end

  // transform pipeline and matrix flags
  tag_t  xf_tag;
  vec3_t xf_pt;
  logic  xf_wz;
  logic  scale_flag, flip_flag;

  at3d_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk     (clk),
    .rst     (rst),
    .mat     (mat),
    .in_tag  (iss_tag),
    .in_pt   (iss_pt),
    .out_tag (xf_tag),
    .out_pt  (xf_pt),
    .out_wz  (xf_wz)
  );

  at3d_flags #(.FRAC_BITS(FRAC_BITS)) u_flags (
    .clk              (clk),
    .mat              (mat),
    .has_scale        (scale_flag),
    .flips_handedness (flip_flag)
  );

  // fold slots into one result
  vec3_t acc_first, acc_second, first_next, second_next;
  logic  acc_wz, wz_next;

  always_comb begin
    first_next  = acc_first;
    second_next = xf_tag.first ? vec3_t'('0) : acc_second;
    wz_next     = (xf_tag.first ? 1'b0 : acc_wz) | xf_wz;
    unique case (xf_tag.role)
      ROLE_FIRST: begin
        first_next = xf_pt;
      end
      ROLE_SECOND: begin
        second_next = xf_pt;
      end
      ROLE_BOX: begin
        if (xf_tag.first) begin
          first_next  = xf_pt;
          second_next = xf_pt;
        end else begin
          first_next.x  = (xf_pt.x < acc_first.x)  ? xf_pt.x : acc_first.x;
          first_next.y  = (xf_pt.y < acc_first.y)  ? xf_pt.y : acc_first.y;
          first_next.z  = (xf_pt.z < acc_first.z)  ? xf_pt.z : acc_first.z;
          second_next.x = (xf_pt.x > acc_second.x) ? xf_pt.x : acc_second.x;
          second_next.y = (xf_pt.y > acc_second.y) ? xf_pt.y : acc_second.y;
          second_next.z = (xf_pt.z > acc_second.z) ? xf_pt.z : acc_second.z;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (xf_tag.valid) begin
      acc_first  <= first_next;
      acc_second <= second_next;
      acc_wz     <= wz_next;
    end
    if (xf_tag.valid && xf_tag.last) begin
      out_first_x      <= first_next.x;
      out_first_y      <= first_next.y;
      out_first_z      <= first_next.z;
      out_second_x     <= second_next.x;
      out_second_y     <= second_next.y;
      out_second_z     <= second_next.z;
      w_zero           <= wz_next;
      has_scale        <= scale_flag;
      flips_handedness <= flip_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= xf_tag.valid && xf_tag.last;
    end
  end

  // box keeps issuing after the transfer
  a_box_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_BOX) |=> busy)
    else $error("box transfer did not hold busy");

  // single-slot kinds never raise busy
  a_single_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_POINT || kind == KIND_VECTOR)) |=> !busy)
    else $error("single-slot transfer raised busy");

  // ray takes exactly two issue slots
  a_ray_two: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_RAY) |=> (busy ##1 !busy))
    else $error("ray issue length wrong");

endmodule
